[rtl/tpr_pkg.sv]
// Package for the PCR restamper: widths, constants and shared types.
// Used by tpr_divider and ts_pcr_restamper.
package tpr_pkg;
	localparam int PID_W = 13;
	localparam int PCR_W = 42;
	localparam int NPCR_W = 64;
	localparam int PAD_W = 48;
	localparam int RATE_W = 32;
	localparam int BYTE_POS_WIDTH_DEF = 48;
	localparam logic [PID_W-1:0] NULL_PID = 13'h1fff;
	localparam logic [PAD_W-1:0] PKT_BYTES = 48'd188;
	localparam logic [31:0] TICKS_PER_BYTE = 32'd216000000;
	localparam logic [1:0] MODE_REWRITE_A = 2'd2;
	localparam logic [1:0] MODE_REWRITE_B = 2'd3;
	localparam logic CFG_PCR_MODE = 1'b0;
	localparam logic CFG_BITRATE = 1'b1;
	localparam int QW = 64 + 32 + 2;
	localparam int DIV_CNT_W = 7;
endpackage

[rtl/tpr_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses tpr_pkg; divides a 98-bit dividend by a 32-bit divisor.
module tpr_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [tpr_pkg::QW-1:0] dividend,
	input logic [tpr_pkg::RATE_W-1:0] divisor,
	output logic done,
	output logic [tpr_pkg::NPCR_W-1:0] quotient
);
	import tpr_pkg::*;

	logic [QW-1:0] q_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [RATE_W:0] shifted;
	logic [RATE_W:0] diff;

	always_comb begin
		shifted = {rem_q, q_q[QW-1]};
		diff = shifted - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			rem_q <= '0;
			div_q <= (divisor == '0) ? RATE_W'(1) : divisor;
		end else if (busy_q) begin
			if (!diff[RATE_W]) begin
				rem_q <= diff[RATE_W-1:0];
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[RATE_W-1:0];
				q_q <= {q_q[QW-2:0], 1'b0};
			end
		end
	end

	assign quotient = q_q[NPCR_W-1:0];
endmodule

[rtl/ts_pcr_restamper.sv]
// PCR restamper top level: per-PID table memory, control sequencer, outputs.
// Uses tpr_pkg and tpr_divider.
//
// Input channel in_valid/in_stall carries one packet's header facts per
// transaction; output channel out_valid/out_stall returns one result each.
// Items are handled one at a time. Without a restamp the input passes the
// states READ (table read) and EVAL (compare and write), and the result is
// registered on leaving EVAL. A restamp runs the bit-serial divider (98
// quotient bits, one per cycle) after EVAL; the result is registered when
// the divider is done.
// Reset starts a clearing pass over the 8192-entry table, one entry per cycle,
// during which in_stall stays high; config writes still land.
// While the receiver stalls, the result holds in the output register; the
// next input is taken once the result has left the register.
module ts_pcr_restamper #(
	parameter int BYTE_POS_WIDTH = tpr_pkg::BYTE_POS_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [tpr_pkg::RATE_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [tpr_pkg::PID_W-1:0] packet_pid,
	input logic has_pcr,
	input logic [tpr_pkg::PCR_W-1:0] orig_pcr,
	input logic [BYTE_POS_WIDTH-1:0] byte_position,
	input logic clear_padding,
	output logic out_valid,
	input logic out_stall,
	output logic [tpr_pkg::NPCR_W-1:0] new_pcr,
	output logic rewrite_pcr,
	output logic [tpr_pkg::PAD_W-1:0] padding_bytes
);
	import tpr_pkg::*;

	localparam int EW = NPCR_W + PCR_W + BYTE_POS_WIDTH;

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_DIV, ST_OUT}
		state_t;

	state_t state_q;
	logic [PID_W-1:0] clr_q;
	logic [1:0] mode_q;
	logic [RATE_W-1:0] rate_q;
	logic [PAD_W-1:0] pad_q;

	logic [EW-1:0] mem [2**PID_W];
	logic [EW-1:0] rd_q;
	logic mem_we;
	logic [PID_W-1:0] mem_addr;
	logic [EW-1:0] mem_wd;

	logic [PID_W-1:0] pid_q;
	logic pcr_q;
	logic [PCR_W-1:0] opcr_q;
	logic [BYTE_POS_WIDTH-1:0] pos_q;
	logic [NPCR_W-1:0] last_rs_q;

	logic [NPCR_W-1:0] rd_rs;
	logic [PCR_W-1:0] rd_op;
	logic [BYTE_POS_WIDTH-1:0] rd_pos;
	logic [BYTE_POS_WIDTH-1:0] delta;
	logic [QW-1:0] dividend;
	logic div_start;
	logic div_done;
	logic [NPCR_W-1:0] quot;
	logic [NPCR_W-1:0] sum;
	logic restamp;
	logic [PAD_W-1:0] pad_next;

	assign rd_rs = rd_q[EW-1 -: NPCR_W];
	assign rd_op = rd_q[BYTE_POS_WIDTH +: PCR_W];
	assign rd_pos = rd_q[BYTE_POS_WIDTH-1:0];
	assign delta = pos_q - rd_pos;
	assign dividend = QW'(delta) * QW'(TICKS_PER_BYTE);
	assign restamp = (rd_rs != '0) && (rd_op < opcr_q);
	assign div_start = (state_q == ST_EVAL) && pcr_q && restamp;
	assign sum = last_rs_q + quot;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		pad_next = clear_padding ? '0 : pad_q;
		if (packet_pid == NULL_PID)
			pad_next = pad_next + PKT_BYTES;
	end

	tpr_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dividend),
		.divisor(rate_q),
		.done(div_done),
		.quotient(quot)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_addr = pid_q;
		mem_wd = {NPCR_W'(opcr_q), opcr_q, pos_q};
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_addr = clr_q;
			mem_wd = '0;
		end else if (state_q == ST_IDLE) begin
			mem_addr = packet_pid;
		end else if (state_q == ST_EVAL) begin
			mem_we = pcr_q && !restamp;
		end else if (state_q == ST_DIV) begin
			mem_we = div_done;
			mem_wd = {sum, opcr_q, pos_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wd;
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			rate_q <= RATE_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == CFG_PCR_MODE)
				mode_q <= cfg_data[1:0];
			else
				rate_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pid_q <= packet_pid;
			pcr_q <= has_pcr;
			opcr_q <= orig_pcr;
			pos_q <= byte_position;
		end
		if (state_q == ST_EVAL)
			last_rs_q <= rd_rs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			pad_q <= '0;
			out_valid <= 1'b0;
			new_pcr <= '0;
			rewrite_pcr <= 1'b0;
			padding_bytes <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						pad_q <= pad_next;
						padding_bytes <= pad_next;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (!pcr_q) begin
						new_pcr <= '0;
						rewrite_pcr <= 1'b0;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else if (restamp) begin
						state_q <= ST_DIV;
					end else begin
						new_pcr <= NPCR_W'(opcr_q);
						rewrite_pcr <= 1'b0;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						new_pcr <= sum;
						rewrite_pcr <= (mode_q == MODE_REWRITE_A) ||
							(mode_q == MODE_REWRITE_B);
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT)
		else $error("result valid outside output state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_rewrite_restamp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && rewrite_pcr |-> $past(state_q) == ST_DIV)
		else $error("rewrite without restamp");
endmodule
